FILE: hdl/linear_3d_point_interpolator_core_defines.svh
// Assertion macros shared by the interpolator RTL.
// Needs clk and arst_n in scope where a macro is used.
`ifndef LINEAR_3D_POINT_INTERPOLATOR_CORE_DEFINES_SVH
`define LINEAR_3D_POINT_INTERPOLATOR_CORE_DEFINES_SVH

// same-cycle implication, checked out of reset
`define L3D_ASSERT_NOW(label, cond, conseq, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (conseq)) \
		else $error(msg);

// next-cycle implication, checked out of reset
`define L3D_ASSERT_NEXT(label, cond, conseq, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (conseq)) \
		else $error(msg);

`endif

FILE: hdl/l3d_pkg.sv
// Shared types and constants of the 3D line interpolator.
// No dependencies.
package l3d_pkg;

	localparam int MAX_POINTS   = 64;
	localparam int INDEX_BITS   = 6;
	localparam int COORD_BITS_D = 24;

	localparam logic [INDEX_BITS-1:0] MAX_INDEX = INDEX_BITS'(MAX_POINTS - 1);

	// per-cycle command broadcast to the three axis lanes
	typedef struct packed {
		logic load;     // capture a new move
		logic div_en;   // one divider iteration
		logic adv;      // step the running coordinate
		logic use_end;  // present the exact end coordinate
	} l3d_lane_ctrl_t;

	// point bookkeeping handed to the merge stage
	typedef struct packed {
		logic                  valid;
		logic                  last;
		logic [INDEX_BITS-1:0] index;
	} l3d_emit_t;

endpackage

FILE: hdl/l3d_lane.sv
// One axis lane: restoring divider for (end - start) / n and a running accumulator.
// Depends on l3d_pkg.
module l3d_lane
	import l3d_pkg::*;
#(
	parameter int COORD_BITS = COORD_BITS_D
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  l3d_lane_ctrl_t               ctrl,
	input  logic signed [COORD_BITS-1:0] start_c,
	input  logic signed [COORD_BITS-1:0] end_c,
	input  logic [INDEX_BITS-1:0]        divisor,
	output logic signed [COORD_BITS-1:0] coord
);

	localparam int DW = COORD_BITS + 1;

	logic signed [DW-1:0]     diff;
	logic [DW-1:0]            mag;
	logic signed [DW-1:0]     acc_q;
	logic [COORD_BITS-1:0]    end_q;
	logic                     neg_q;
	logic [DW-1:0]            quo_q;
	logic [INDEX_BITS-1:0]    rem_q;
	logic [INDEX_BITS:0]      rem_sh;
	logic                     fits;

	assign diff = DW'(end_c) - DW'(start_c);
	assign mag  = diff[DW-1] ? DW'(-diff) : DW'(diff);

	// shift in the next dividend bit; remainder stays below the divisor
	assign rem_sh = {rem_q, quo_q[DW-1]};
	assign fits   = rem_sh >= {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
			end_q <= '0;
			neg_q <= 1'b0;
			quo_q <= '0;
			rem_q <= '0;
		end else if (ctrl.load) begin
			acc_q <= DW'(start_c);
			end_q <= end_c;
			neg_q <= diff[DW-1];
			quo_q <= mag;
			rem_q <= '0;
		end else if (ctrl.div_en) begin
			quo_q <= {quo_q[DW-2:0], fits};
			rem_q <= fits ? INDEX_BITS'(rem_sh - {1'b0, divisor}) : rem_sh[INDEX_BITS-1:0];
		end else if (ctrl.adv) begin
			acc_q <= neg_q ? acc_q - $signed(quo_q) : acc_q + $signed(quo_q);
		end
	end

	assign coord = ctrl.use_end ? $signed(end_q) : acc_q[COORD_BITS-1:0];

endmodule

FILE: hdl/l3d_merge.sv
// Merge stage: registers the three lane coordinates with index and last flag.
// Depends on l3d_pkg.
module l3d_merge
	import l3d_pkg::*;
#(
	parameter int COORD_BITS = COORD_BITS_D
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  l3d_emit_t                    emit,
	input  logic signed [COORD_BITS-1:0] lane_x,
	input  logic signed [COORD_BITS-1:0] lane_y,
	input  logic signed [COORD_BITS-1:0] lane_z,
	output logic                         strobe,
	output logic [INDEX_BITS-1:0]        point_index,
	output logic signed [COORD_BITS-1:0] point_x,
	output logic signed [COORD_BITS-1:0] point_y,
	output logic signed [COORD_BITS-1:0] point_z,
	output logic                         last_point
);

	logic valid_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= emit.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (emit.valid) begin
			point_index <= emit.index;
			last_point  <= emit.last;
			point_x     <= lane_x;
			point_y     <= lane_y;
			point_z     <= lane_z;
		end
	end

	assign strobe = valid_s1;

endmodule

FILE: hdl/linear_3d_point_interpolator_core.sv
// Top level of the 3D straight-line point interpolator.
// Depends on l3d_pkg, l3d_lane, l3d_merge and the assertion macro header.
//
// channel   | direction | handshake              | payload
// ----------+-----------+------------------------+---------------------------------------
// move      | in        | start & !busy          | start/end x,y,z, segment_count
// point     | out       | strobe (one cycle)     | point_index, point_x/y/z, last_point
//
// A move runs through load, divide and emit and yields n + 1 points, n = min(segment_count, 63):
// the bit-serial dividers in the lanes (one quotient bit per cycle) work in the divide
// state, then one point leaves per cycle. Each point appears on the outputs in the cycle
// after it is formed, for exactly one cycle; the receiver cannot stall it.
// busy is high from the accepting edge until the end point has been formed.
// Reset (arst_n low) returns to idle at once and drops the strobe.
`include "linear_3d_point_interpolator_core_defines.svh"

module linear_3d_point_interpolator_core
	import l3d_pkg::*;
#(
	parameter int COORD_BITS = COORD_BITS_D
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic signed [COORD_BITS-1:0] start_x,
	input  logic signed [COORD_BITS-1:0] end_x,
	input  logic signed [COORD_BITS-1:0] start_y,
	input  logic signed [COORD_BITS-1:0] end_y,
	input  logic signed [COORD_BITS-1:0] start_z,
	input  logic signed [COORD_BITS-1:0] end_z,
	input  logic [INDEX_BITS-1:0]        segment_count,
	output logic                         strobe,
	output logic [INDEX_BITS-1:0]        point_index,
	output logic signed [COORD_BITS-1:0] point_x,
	output logic signed [COORD_BITS-1:0] point_y,
	output logic signed [COORD_BITS-1:0] point_z,
	output logic                         last_point
);

	// divider runs one iteration per quotient bit
	localparam int DIV_STEPS = COORD_BITS + 1;
	localparam int CNT_BITS  = $clog2(DIV_STEPS + 1);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_DIV  = 2'd1;
	localparam logic [1:0] ST_EMIT = 2'd2;

	logic [1:0]            state_q;
	logic [CNT_BITS-1:0]   div_cnt_q;
	logic [INDEX_BITS-1:0] n_q;
	logic [INDEX_BITS-1:0] idx_q;
	logic                  accept;
	logic                  at_end;
	l3d_lane_ctrl_t        ctrl;
	l3d_emit_t             emit;
	logic signed [COORD_BITS-1:0] lane_x, lane_y, lane_z;

	assign accept = start && !busy;
	assign busy   = state_q != ST_IDLE;
	assign at_end = idx_q == n_q;

	// sequencer: load, divide, then walk the points
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			div_cnt_q <= '0;
			idx_q     <= '0;
			n_q       <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						// counts above capacity saturate
						n_q       <= (segment_count > MAX_INDEX) ? MAX_INDEX : segment_count;
						div_cnt_q <= '0;
						idx_q     <= '0;
						state_q   <= ST_DIV;
					end
				end
				ST_DIV: begin
					div_cnt_q <= div_cnt_q + 1'b1;
					if (div_cnt_q == CNT_BITS'(DIV_STEPS - 1)) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					idx_q <= idx_q + 1'b1;
					if (at_end) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_comb begin
		ctrl.load    = accept;
		ctrl.div_en  = state_q == ST_DIV;
		ctrl.adv     = (state_q == ST_EMIT) && !at_end;
		ctrl.use_end = at_end;
		emit.valid   = state_q == ST_EMIT;
		emit.last    = at_end;
		emit.index   = idx_q;
	end

	// divisor is n; with n = 0 only the end point leaves, so the step is never used
	l3d_lane #(.COORD_BITS(COORD_BITS)) u_lane_x (
		.clk(clk), .arst_n(arst_n), .ctrl(ctrl),
		.start_c(start_x), .end_c(end_x), .divisor(n_q), .coord(lane_x)
	);

	l3d_lane #(.COORD_BITS(COORD_BITS)) u_lane_y (
		.clk(clk), .arst_n(arst_n), .ctrl(ctrl),
		.start_c(start_y), .end_c(end_y), .divisor(n_q), .coord(lane_y)
	);

	l3d_lane #(.COORD_BITS(COORD_BITS)) u_lane_z (
		.clk(clk), .arst_n(arst_n), .ctrl(ctrl),
		.start_c(start_z), .end_c(end_z), .divisor(n_q), .coord(lane_z)
	);

	l3d_merge #(.COORD_BITS(COORD_BITS)) u_merge (
		.clk(clk), .arst_n(arst_n), .emit(emit),
		.lane_x(lane_x), .lane_y(lane_y), .lane_z(lane_z),
		.strobe(strobe), .point_index(point_index),
		.point_x(point_x), .point_y(point_y), .point_z(point_z),
		.last_point(last_point)
	);

	// a transaction on the move port starts work
	`L3D_ASSERT_NEXT(a_accept_busy, accept, busy, "accepted move did not raise busy")
	// points of one move come out back to back until the end point
	`L3D_ASSERT_NEXT(a_points_contig, strobe && !last_point, strobe, "gap inside a point run")
	// end point carries the saturated count as its index
	`L3D_ASSERT_NOW(a_last_index, strobe && last_point, point_index == n_q,
		"end point index differs from segment count")
	// every point was formed while the block was busy
	`L3D_ASSERT_NOW(a_strobe_busy, strobe, $past(busy), "point emitted while idle")

endmodule
